FILE: hdl/pot_pkg.sv
// shared types, constants and a lane helper for the primitive overlap test
// no dependencies; imported by every module in hdl/
package pot_pkg;

  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 48;
  localparam int CMD_W      = 2;
  localparam int PACK_W     = 3 * COORD_BITS;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int RAD_W      = COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int RSQ_W      = 2 * RAD_W;
  localparam int DIST_W     = 2 * COORD_BITS + 2;
  localparam int LATENCY    = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPH_SPH = 2'd0,
    CMD_BOX_BOX = 2'd1,
    CMD_SPH_BOX = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                             valid;
    cmd_t                             cmd;
    logic                             box_hit;
    logic [RAD_W-1:0]                 rad;
    logic [2:0][COORD_BITS-1:0]       op1;
    logic [2:0][COORD_BITS-1:0]       op2;
  } s1_t;

  typedef struct packed {
    logic                             valid;
    cmd_t                             cmd;
    logic                             box_hit;
    logic [RAD_W-1:0]                 rad;
    logic [2:0][DIFF_W-1:0]           d;
  } s2_t;

  typedef struct packed {
    logic                             valid;
    cmd_t                             cmd;
    logic                             box_hit;
    logic [RSQ_W-1:0]                 rsq;
    logic [2:0][SQ_W-1:0]             sq;
  } s3_t;

  // bits above the 48-bit field read as zero
  function automatic logic signed [COORD_BITS-1:0] lane(input logic [FIELD_W-1:0] word,
                                                        input logic [1:0] axis);
    logic [PACK_W-1:0] w;
    w = '0;
    for (int i = 0; i < PACK_W; i++) begin
      if (i < FIELD_W) begin
        w[i] = word[i];
      end
    end
    return $signed(w[axis*COORD_BITS +: COORD_BITS]);
  endfunction

endpackage

FILE: hdl/primitive_overlap_test_top.sv
// top level of the sphere / box overlap test
// depends on pot_pkg, pot_front, pot_square, pot_decide
//
// usage:
//   a request is taken at a rising edge with start high and busy low. busy is
//   always low, so a request may be issued in every cycle. in_cmd picks the
//   pair kind (sphere-sphere, box-box, sphere-box, absent); in_a_lo/in_a_hi
//   and in_b_lo/in_b_hi carry the two primitives as packed signed lanes, or
//   the radius in the low lane of the _hi word for a sphere.
//   each request gives one result: out_valid is high for exactly one cycle
//   with out_hit, after the request has passed the four register stages.
//   out_hit is low when out_valid is low.
//   throughput is one request per cycle, set by the four register stages
//   (unpack/clamp, difference, square, sum/compare) all advancing together.
//   the receiver cannot stall; results are taken in the cycle they appear.
//   synchronous reset (rst_n low) drops every request in flight and clears
//   out_valid and out_hit; the stage data fields are not reset.
module primitive_overlap_test_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pot_pkg::CMD_W-1:0]     in_cmd,
  input  logic [pot_pkg::FIELD_W-1:0]   in_a_lo,
  input  logic [pot_pkg::FIELD_W-1:0]   in_a_hi,
  input  logic [pot_pkg::FIELD_W-1:0]   in_b_lo,
  input  logic [pot_pkg::FIELD_W-1:0]   in_b_hi,
  output logic                          out_valid,
  output logic                          out_hit
);
  import pot_pkg::*;

  logic req_take;
  s2_t  s2;
  s3_t  s3;

  assign busy     = 1'b0;
  assign req_take = start & ~busy;

  pot_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_take),
    .cmd       (in_cmd),
    .a_lo      (in_a_lo),
    .a_hi      (in_a_hi),
    .b_lo      (in_b_lo),
    .b_hi      (in_b_hi),
    .s2        (s2)
  );

  pot_square u_square (
    .clk   (clk),
    .rst_n (rst_n),
    .s2    (s2),
    .s3    (s3)
  );

  pot_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3        (s3),
    .res_valid (out_valid),
    .res_hit   (out_hit)
  );

  // every request comes out exactly once, at the end of the pipeline
  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |-> ##LATENCY out_valid)
    else $error("request did not produce a result");

  a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req_take, LATENCY))
    else $error("result without a request");

  a_absent_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (req_take && in_cmd == CMD_NONE) |-> ##LATENCY !out_hit)
    else $error("absent primitive reported a hit");

  a_hit_strobed: assert property (@(posedge clk) disable iff (!rst_n)
    out_hit |-> out_valid)
    else $error("hit outside a result cycle");

endmodule

FILE: hdl/pot_front.sv
// front end: lane unpack, clamp, box compares (stage 1) and axis differences (stage 2)
// depends on pot_pkg
module pot_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              req_valid,
  input  logic [pot_pkg::CMD_W-1:0]         cmd,
  input  logic [pot_pkg::FIELD_W-1:0]       a_lo,
  input  logic [pot_pkg::FIELD_W-1:0]       a_hi,
  input  logic [pot_pkg::FIELD_W-1:0]       b_lo,
  input  logic [pot_pkg::FIELD_W-1:0]       b_hi,
  output pot_pkg::s2_t                      s2
);
  import pot_pkg::*;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;

  always_comb begin
    logic signed [COORD_BITS-1:0] amin, amax, bmin, bmax, q;
    logic [2:0] ax_hit;
    s1_nxt         = '0;
    s1_nxt.valid   = req_valid;
    s1_nxt.cmd     = cmd_t'(cmd);
    for (int ax = 0; ax < 3; ax++) begin
      amin = lane(a_lo, 2'(ax));
      amax = lane(a_hi, 2'(ax));
      bmin = lane(b_lo, 2'(ax));
      bmax = lane(b_hi, 2'(ax));
      // x counts touching faces only where a's max meets b's min; y and z are strict
      if (ax == 0) begin
        ax_hit[ax] = (amax >= bmin) && (amin < bmax);
      end else begin
        ax_hit[ax] = (amax > bmin) && (amin < bmax);
      end
      // clamp center into box: raise to min, then lower to max
      q = amin;
      if (q < bmin) begin
        q = bmin;
      end
      if (q > bmax) begin
        q = bmax;
      end
      if (cmd_t'(cmd) == CMD_SPH_BOX) begin
        s1_nxt.op1[ax] = q;
        s1_nxt.op2[ax] = amin;
      end else begin
        s1_nxt.op1[ax] = amin;
        s1_nxt.op2[ax] = bmin;
      end
    end
    s1_nxt.box_hit = &ax_hit;
    if (cmd_t'(cmd) == CMD_SPH_SPH) begin
      s1_nxt.rad = {1'b0, a_hi[COORD_BITS-1:0]} + {1'b0, b_hi[COORD_BITS-1:0]};
    end else begin
      s1_nxt.rad = {1'b0, a_hi[COORD_BITS-1:0]};
    end
  end

  always_comb begin
    s2_nxt         = '0;
    s2_nxt.valid   = s1_r.valid;
    s2_nxt.cmd     = s1_r.cmd;
    s2_nxt.box_hit = s1_r.box_hit;
    s2_nxt.rad     = s1_r.rad;
    for (int ax = 0; ax < 3; ax++) begin
      s2_nxt.d[ax] = DIFF_W'($signed({s1_r.op1[ax][COORD_BITS-1], s1_r.op1[ax]})
                   - $signed({s1_r.op2[ax][COORD_BITS-1], s1_r.op2[ax]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
    end else begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign s2 = s2_r;

endmodule

FILE: hdl/pot_square.sv
// stage 3: squares of the axis differences and of the radius term
// depends on pot_pkg
module pot_square (
  input  logic          clk,
  input  logic          rst_n,
  input  pot_pkg::s2_t  s2,
  output pot_pkg::s3_t  s3
);
  import pot_pkg::*;

  s3_t s3_r, s3_nxt;

  always_comb begin
    logic signed [2*DIFF_W-1:0] prod;
    s3_nxt         = '0;
    s3_nxt.valid   = s2.valid;
    s3_nxt.cmd     = s2.cmd;
    s3_nxt.box_hit = s2.box_hit;
    s3_nxt.rsq     = RSQ_W'(s2.rad * s2.rad);
    for (int ax = 0; ax < 3; ax++) begin
      prod          = $signed(s2.d[ax]) * $signed(s2.d[ax]);
      s3_nxt.sq[ax] = prod[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else begin
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

FILE: hdl/pot_decide.sv
// stage 4: distance sum, radius compare (box-box uses the stage 1 compares) and result register
// depends on pot_pkg
module pot_decide (
  input  logic          clk,
  input  logic          rst_n,
  input  pot_pkg::s3_t  s3,
  output logic          res_valid,
  output logic          res_hit
);
  import pot_pkg::*;

  logic              valid_r, valid_nxt;
  logic              hit_r, hit_nxt;
  logic [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0] rsq;

  assign dist_sum = DIST_W'(s3.sq[0]) + DIST_W'(s3.sq[1]) + DIST_W'(s3.sq[2]);
  assign rsq      = DIST_W'(s3.rsq);

  always_comb begin
    valid_nxt = s3.valid;
    case (s3.cmd)
      CMD_SPH_SPH: hit_nxt = (dist_sum <= rsq);
      CMD_BOX_BOX: hit_nxt = s3.box_hit;
      CMD_SPH_BOX: hit_nxt = (dist_sum < rsq);
      default:     hit_nxt = 1'b0;
    endcase
    hit_nxt = hit_nxt & s3.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
  end

  assign res_valid = valid_r;
  assign res_hit   = hit_r;

endmodule
